@@ rtl/lmfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lmfd_pkg
// Shared types and constants for the LZSS decompressor with MSB-first flags.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfd_pkg;

  localparam int WIN_DEPTH = 4096;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int LEN_W     = 33;
  localparam int CNT_W     = 5;

  // window write position after reset
  localparam logic [AW-1:0]    WIN_START = AW'(32'hFEE % WIN_DEPTH);
  localparam logic [7:0]       INV_MASK  = 8'hFF;
  localparam logic [3:0]       FLAG_CNT  = 4'd8;
  localparam logic [CNT_W-1:0] LEN_BIAS  = CNT_W'(3);
  localparam logic [AW:0]      FILL_MAX  = (AW+1)'(WIN_DEPTH);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

endpackage

`default_nettype wire

@@ rtl/lzss_msb_flag_decompressor_unit.sv @@
// ----------------------------------------------------------------------------
// lzss_msb_flag_decompressor_unit
// LZSS decompressor, inverted input, MSB-first flags, 4K window.
// A literal is registered into the output register in the cycle after it is accepted.
// A match copies 3 to 18 bytes (fewer if the output length is reached), one
// byte per cycle via the window RAM read port when output is not stalled.
// Reset (sync, active low) and the last word of a stream empty the window by
// zeroing its fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_msb_flag_decompressor_unit
  import lmfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_word_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  state_t           state_r, state_nxt;
  logic [7:0]       flag_bits_r, flag_bits_nxt;
  logic [3:0]       flags_left_r, flags_left_nxt;
  logic [7:0]       pend_low_r, pend_low_nxt;
  logic             have_pend_r, have_pend_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW:0]      fill_r, fill_nxt;
  logic [LEN_W-1:0] produced_r, produced_nxt;
  logic [LEN_W-1:0] out_length_r, out_length_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             hit_r, hit_nxt;
  logic             fwd_r, fwd_nxt;
  logic [7:0]       fwd_byte_r, fwd_byte_nxt;
  logic             last_r, last_nxt;
  out_word_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             can_emit, in_acc, has_room, emit, run_last, end_now, issue, clear;
  logic [7:0]       in_inv, emit_byte, copy_byte, ram_rd_data;
  logic [LEN_W-1:0] produced_inc;
  logic [AW:0]      fill_wr;
  logic [AW-1:0]    src_ofs;
  logic [11:0]      word_pos;

  lmfd_ram #(
    .WIDTH(8),
    .DEPTH(WIN_DEPTH)
  ) u_window (
    .clk    (clk),
    .wr_en  (emit),
    .wr_addr(wp_r),
    .wr_data(emit_byte),
    .rd_en  (issue),
    .rd_addr(src_r),
    .rd_data(ram_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    in_inv       = in_data.in_byte ^ INV_MASK;
    can_emit     = !out_valid_r || !out_stall;
    in_stall     = !((state_r == ST_IDLE) && can_emit);
    in_acc       = in_valid && !in_stall;
    has_room     = produced_r < out_length_r;
    produced_inc = produced_r + LEN_W'(1);
    // reads beyond the fill count return zero; the RAM entries are not cleared
    copy_byte    = !hit_r ? 8'h00 : (fwd_r ? fwd_byte_r : ram_rd_data);
    word_pos     = {in_inv, pend_low_r[7:4]};

    state_nxt      = state_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    pend_low_nxt   = pend_low_r;
    have_pend_nxt  = have_pend_r;
    wp_nxt         = wp_r;
    fill_nxt       = fill_r;
    produced_nxt   = produced_r;
    out_length_nxt = cfg_valid ? cfg_data : out_length_r;
    src_nxt        = src_r;
    rem_nxt        = rem_r;
    rd_vld_nxt     = rd_vld_r;
    hit_nxt        = hit_r;
    fwd_nxt        = fwd_r;
    fwd_byte_nxt   = fwd_byte_r;
    last_nxt       = last_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    emit      = 1'b0;
    emit_byte = in_inv;
    run_last  = 1'b0;
    end_now   = 1'b0;
    issue     = 1'b0;
    clear     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          clear = in_data.in_last;
          if (has_room) begin
            priority if (flags_left_r == 4'd0) begin
              flag_bits_nxt  = in_inv;
              flags_left_nxt = FLAG_CNT;
            end else if (flag_bits_r[7]) begin
              emit           = 1'b1;
              run_last       = 1'b1;
              flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
              flags_left_nxt = flags_left_r - 4'd1;
            end else if (!have_pend_r) begin
              pend_low_nxt  = in_inv;
              have_pend_nxt = 1'b1;
            end else begin
              have_pend_nxt  = 1'b0;
              src_nxt        = word_pos[AW-1:0];
              rem_nxt        = CNT_W'(pend_low_r[3:0]) + LEN_BIAS;
              rd_vld_nxt     = 1'b0;
              last_nxt       = in_data.in_last;
              state_nxt      = ST_COPY;
              flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
              flags_left_nxt = flags_left_r - 4'd1;
              // stream end waits until the copy has finished
              clear          = 1'b0;
            end
          end
        end
      end
      ST_COPY: begin
        if (rd_vld_r && can_emit) begin
          emit       = 1'b1;
          emit_byte  = copy_byte;
          end_now    = (rem_r == '0) || (produced_inc == out_length_r);
          run_last   = end_now;
          rd_vld_nxt = 1'b0;
          if (end_now) begin
            state_nxt = ST_IDLE;
            clear     = last_r;
          end
        end
        issue = (rem_r != '0) && (!rd_vld_r || (emit && !end_now));
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    fill_wr = (emit && (fill_r != FILL_MAX)) ? fill_r + (AW+1)'(1) : fill_r;
    src_ofs = src_r - WIN_START;

    if (issue) begin
      src_nxt      = src_r + AW'(1);
      rem_nxt      = rem_r - CNT_W'(1);
      rd_vld_nxt   = 1'b1;
      hit_nxt      = {1'b0, src_ofs} < fill_wr;
      // read and write of one entry in the same cycle: take the new byte
      fwd_nxt      = emit && (src_r == wp_r);
      fwd_byte_nxt = emit_byte;
    end

    if (emit) begin
      wp_nxt                = wp_r + AW'(1);
      fill_nxt              = fill_wr;
      produced_nxt          = produced_inc;
      out_nxt.out_byte      = emit_byte;
      out_nxt.run_last      = run_last;
      out_nxt.stream_done   = produced_inc == out_length_r;
      out_valid_nxt         = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (clear) begin
      wp_nxt         = WIN_START;
      fill_nxt       = '0;
      produced_nxt   = '0;
      flag_bits_nxt  = '0;
      flags_left_nxt = '0;
      pend_low_nxt   = '0;
      have_pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      have_pend_r  <= 1'b0;
      wp_r         <= WIN_START;
      fill_r       <= '0;
      produced_r   <= '0;
      out_length_r <= '0;
      rem_r        <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      fwd_r        <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      have_pend_r  <= have_pend_nxt;
      wp_r         <= wp_nxt;
      fill_r       <= fill_nxt;
      produced_r   <= produced_nxt;
      out_length_r <= out_length_nxt;
      rem_r        <= rem_nxt;
      rd_vld_r     <= rd_vld_nxt;
      hit_r        <= hit_nxt;
      fwd_r        <= fwd_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_low_r <= pend_low_nxt;
    src_r      <= src_nxt;
    fwd_byte_r <= fwd_byte_nxt;
    out_r      <= out_nxt;
  end

  a_no_accept_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> in_stall)
    else $error("input word accepted during a match copy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("window fill count beyond window size");

  a_read_only_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_COPY))
    else $error("window read outstanding outside a match copy");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> can_emit)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

@@ rtl/lmfd_ram.sv @@
// ----------------------------------------------------------------------------
// lmfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
